// File: rtl/indexed_deque_defines.svh
// ---------------------------------------------------------------------------
// indexed_deque assertion macros
// shared property shapes for the deque checker
// ---------------------------------------------------------------------------
`ifndef INDEXED_DEQUE_DEFINES_SVH
`define INDEXED_DEQUE_DEFINES_SVH

// same-cycle implication, disabled while reset is asserted
`define IDQ_ASSERT_IMPLY(label, clk, rst_n, ante, cons, msg) \
	label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
		else $error(msg);

// next-cycle implication, disabled while reset is asserted
`define IDQ_ASSERT_NEXT(label, clk, rst_n, ante, cons, msg) \
	label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
		else $error(msg);

`endif

// File: rtl/idq_pkg.sv
// ---------------------------------------------------------------------------
// idq_pkg
// types and constants shared by the indexed deque modules
// ---------------------------------------------------------------------------
package idq_pkg;

	localparam int DEPTH_DEF       = 16;
	localparam int VALUE_WIDTH_DEF = 32;

	localparam int MODE_W     = 3;
	localparam int IN_VALUE_W = 32;
	localparam int POS_W      = 4;
	localparam int DATA_W     = 32;
	localparam int STATUS_W   = 2;
	localparam int COUNT_W    = 5;
	localparam int S_TDATA_W  = 40;
	localparam int M_TDATA_W  = 40;

	typedef enum logic [MODE_W-1:0] {
		MODE_PUSH_FRONT = 3'd0,
		MODE_PUSH_BACK  = 3'd1,
		MODE_POP_FRONT  = 3'd2,
		MODE_POP_BACK   = 3'd3,
		MODE_REMOVE     = 3'd4,
		MODE_GET        = 3'd5,
		MODE_CONTAINS   = 3'd6,
		MODE_PEEK_BACK  = 3'd7
	} mode_t;

	typedef enum logic [STATUS_W-1:0] {
		ST_OK   = 2'd0,
		ST_MISS = 2'd1,
		ST_FULL = 2'd2
	} status_t;

	// per-request command broadcast to every cell
	typedef struct packed {
		logic shift_up;
		logic append;
		logic shift_down;
	} cell_cmd_t;

endpackage

// File: rtl/idq_cell.sv
// ---------------------------------------------------------------------------
// idq_cell
// one slot of the deque chain: holds a value, moves it to or takes it from
// its neighbors, and compares it against the search key
// ---------------------------------------------------------------------------
module idq_cell #(
	parameter int VALUE_WIDTH = idq_pkg::VALUE_WIDTH_DEF,
	parameter int COUNT_WIDTH = 5,
	parameter int INDEX       = 0
) (
	input  logic                   clk,
	input  idq_pkg::cell_cmd_t     cmd,
	input  logic [COUNT_WIDTH-1:0] count,
	input  logic [COUNT_WIDTH-1:0] rm_index,
	input  logic [VALUE_WIDTH-1:0] key,
	input  logic [VALUE_WIDTH-1:0] lower,
	input  logic [VALUE_WIDTH-1:0] upper,
	output logic [VALUE_WIDTH-1:0] value,
	output logic                   match
);

	localparam logic [COUNT_WIDTH-1:0] MY_IDX = COUNT_WIDTH'(INDEX);

	logic [VALUE_WIDTH-1:0] value_q;
	logic [VALUE_WIDTH-1:0] value_d;

	always_comb begin
		value_d = value_q;
		if (cmd.shift_up) begin
			value_d = lower;
		end else if (cmd.append && (count == MY_IDX)) begin
			value_d = key;
		end else if (cmd.shift_down && (MY_IDX >= rm_index)) begin
			value_d = upper;
		end
	end

	always_ff @(posedge clk) begin
		value_q <= value_d;
	end

	assign value = value_q;
	assign match = (MY_IDX < count) && (value_q == key);

endmodule

// File: rtl/indexed_deque.sv
// ---------------------------------------------------------------------------
// indexed_deque
// double-ended queue built as a chain of slot cells with indexed access
// ---------------------------------------------------------------------------
//  channel  | dir | fields (lsb first)
//  s_*      | in  | mode[2:0], value[34:3], position[38:35], zero[39]
//  m_*      | out | data_out[31:0], status[33:32], count[38:34], zero[39]
//
//  one request per cycle while the output is not stalled; its result is registered and shows in the next cycle
//  the slot chain shifts as a whole when a request is accepted, so remove and contains
//  cost no more than a push; the read mux and match or-tree set the path
//  a new request is taken whenever the result register is empty or drained
//  reset clears the count and the result valid flag, slot contents stay undefined
// ---------------------------------------------------------------------------
module indexed_deque #(
	parameter int DEPTH       = idq_pkg::DEPTH_DEF,
	parameter int VALUE_WIDTH = idq_pkg::VALUE_WIDTH_DEF
) (
	input  logic                          clk,
	input  logic                          arst_n,
	input  logic                          s_tvalid,
	output logic                          s_tready,
	input  logic [idq_pkg::S_TDATA_W-1:0] s_tdata,  // mode, value, position
	output logic                          m_tvalid,
	input  logic                          m_tready,
	output logic [idq_pkg::M_TDATA_W-1:0] m_tdata   // data_out, status, count
);

	localparam int CW = $clog2(DEPTH + 1);
	localparam int RW = (CW > idq_pkg::POS_W) ? CW : idq_pkg::POS_W;

	idq_pkg::mode_t                  mode;
	logic [idq_pkg::IN_VALUE_W-1:0]  value_in;
	logic [idq_pkg::POS_W-1:0]       pos;
	logic [VALUE_WIDTH+31:0]         key_ext;
	logic [VALUE_WIDTH-1:0]          key;

	logic                            accept;
	logic [CW-1:0]                   count_q;
	logic [CW-1:0]                   count_d;
	logic                            full;
	logic                            empty;
	logic                            pos_ok;
	logic [CW-1:0]                   back_idx;

	idq_pkg::cell_cmd_t              cmd;
	idq_pkg::cell_cmd_t              cell_cmd;
	logic [CW-1:0]                   rm_idx;
	logic [RW-1:0]                   rd_idx;
	logic                            take;
	idq_pkg::status_t                status;

	logic [VALUE_WIDTH-1:0]          cell_val [DEPTH];
	logic [DEPTH-1:0]                cell_match;
	logic                            any_match;
	logic [VALUE_WIDTH-1:0]          rd_val;
	logic [VALUE_WIDTH+31:0]         rd_ext;
	logic [idq_pkg::DATA_W-1:0]      data_d;

	logic                            m_valid_q;
	logic [idq_pkg::DATA_W-1:0]      m_data_q;
	idq_pkg::status_t                m_status_q;
	logic [idq_pkg::COUNT_W-1:0]     m_count_q;

	assign mode     = idq_pkg::mode_t'(s_tdata[2:0]);
	assign value_in = s_tdata[34:3];
	assign pos      = s_tdata[38:35];

	// stored values keep only VALUE_WIDTH bits
	assign key_ext = {{VALUE_WIDTH{1'b0}}, value_in};
	assign key     = key_ext[VALUE_WIDTH-1:0];

	assign s_tready = !m_valid_q || m_tready;
	assign accept   = s_tvalid && s_tready;

	assign full     = (count_q == CW'(DEPTH));
	assign empty    = (count_q == '0);
	assign pos_ok   = (RW'(pos) < RW'(count_q));
	assign back_idx = count_q - CW'(1);

	always_comb begin
		cmd     = '0;
		count_d = count_q;
		status  = idq_pkg::ST_OK;
		take    = 1'b0;
		rm_idx  = CW'(pos);
		rd_idx  = RW'(pos);
		unique case (mode)
			idq_pkg::MODE_PUSH_FRONT: begin
				if (full) begin
					status = idq_pkg::ST_FULL;
				end else begin
					cmd.shift_up = 1'b1;
					count_d      = count_q + CW'(1);
				end
			end
			idq_pkg::MODE_PUSH_BACK: begin
				if (full) begin
					status = idq_pkg::ST_FULL;
				end else begin
					cmd.append = 1'b1;
					count_d    = count_q + CW'(1);
				end
			end
			idq_pkg::MODE_POP_FRONT: begin
				rm_idx = '0;
				rd_idx = '0;
				if (empty) begin
					status = idq_pkg::ST_MISS;
				end else begin
					cmd.shift_down = 1'b1;
					take           = 1'b1;
					count_d        = back_idx;
				end
			end
			idq_pkg::MODE_POP_BACK: begin
				rd_idx = RW'(back_idx);
				if (empty) begin
					status = idq_pkg::ST_MISS;
				end else begin
					take    = 1'b1;
					count_d = back_idx;
				end
			end
			idq_pkg::MODE_REMOVE: begin
				if (pos_ok) begin
					cmd.shift_down = 1'b1;
					take           = 1'b1;
					count_d        = back_idx;
				end else begin
					status = idq_pkg::ST_MISS;
				end
			end
			idq_pkg::MODE_GET: begin
				if (pos_ok) begin
					take = 1'b1;
				end else begin
					status = idq_pkg::ST_MISS;
				end
			end
			idq_pkg::MODE_CONTAINS: begin
				status = any_match ? idq_pkg::ST_OK : idq_pkg::ST_MISS;
			end
			idq_pkg::MODE_PEEK_BACK: begin
				rd_idx = RW'(back_idx);
				if (empty) begin
					status = idq_pkg::ST_MISS;
				end else begin
					take = 1'b1;
				end
			end
		endcase
	end

	assign cell_cmd = accept ? cmd : '0;

	for (genvar i = 0; i < DEPTH; i++) begin : g_cell
		logic [VALUE_WIDTH-1:0] lower;
		logic [VALUE_WIDTH-1:0] upper;

		// cell 0 takes the new value on a front push, the last cell keeps its own
		if (i == 0) begin : g_first
			assign lower = key;
		end else begin : g_mid_lo
			assign lower = cell_val[i-1];
		end
		if (i == DEPTH - 1) begin : g_last
			assign upper = cell_val[i];
		end else begin : g_mid_hi
			assign upper = cell_val[i+1];
		end

		idq_cell #(
			.VALUE_WIDTH(VALUE_WIDTH),
			.COUNT_WIDTH(CW),
			.INDEX      (i)
		) u_cell (
			.clk     (clk),
			.cmd     (cell_cmd),
			.count   (count_q),
			.rm_index(rm_idx),
			.key     (key),
			.lower   (lower),
			.upper   (upper),
			.value   (cell_val[i]),
			.match   (cell_match[i])
		);
	end

	assign any_match = |cell_match;

	always_comb begin
		rd_val = '0;
		for (int i = 0; i < DEPTH; i++) begin
			if (RW'(i) == rd_idx) begin
				rd_val = cell_val[i];
			end
		end
	end

	assign rd_ext = {32'b0, rd_val};
	assign data_d = take ? rd_ext[31:0] : '0;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			count_q   <= '0;
			m_valid_q <= 1'b0;
		end else begin
			if (accept) begin
				count_q   <= count_d;
				m_valid_q <= 1'b1;
			end else if (m_tready) begin
				m_valid_q <= 1'b0;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (accept) begin
			m_data_q   <= data_d;
			m_status_q <= status;
			m_count_q  <= idq_pkg::COUNT_W'(count_d);
		end
	end

	assign m_tvalid = m_valid_q;
	assign m_tdata  = {1'b0, m_count_q, m_status_q, m_data_q};

endmodule

// File: rtl/idq_checker.sv
// ---------------------------------------------------------------------------
// idq_checker
// port-level checks on the indexed deque result stream
// ---------------------------------------------------------------------------
`include "indexed_deque_defines.svh"

module idq_checker #(
	parameter int DEPTH = idq_pkg::DEPTH_DEF
) (
	input logic                          clk,
	input logic                          arst_n,
	input logic                          s_tvalid,
	input logic                          s_tready,
	input logic [idq_pkg::S_TDATA_W-1:0] s_tdata,
	input logic                          m_tvalid,
	input logic                          m_tready,
	input logic [idq_pkg::M_TDATA_W-1:0] m_tdata
);

	logic [1:0] res_status;
	logic [4:0] res_count;
	logic       push_req;

	assign res_status = m_tdata[33:32];
	assign res_count  = m_tdata[38:34];
	assign push_req   = s_tvalid && s_tready &&
		((s_tdata[2:0] == idq_pkg::MODE_PUSH_FRONT) || (s_tdata[2:0] == idq_pkg::MODE_PUSH_BACK));

	`IDQ_ASSERT_IMPLY(a_no_data_on_fail, clk, arst_n,
		m_tvalid && (res_status != idq_pkg::ST_OK), m_tdata[31:0] == 32'd0,
		"data_out not zero on a failed request")

	`IDQ_ASSERT_IMPLY(a_full_count, clk, arst_n,
		m_tvalid && (res_status == idq_pkg::ST_FULL), res_count == 5'(DEPTH),
		"full status with count below depth")

	`IDQ_ASSERT_NEXT(a_push_status, clk, arst_n,
		push_req, m_tvalid && ((res_status == idq_pkg::ST_OK) || (res_status == idq_pkg::ST_FULL)),
		"push answered with a status other than ok or full")

	`IDQ_ASSERT_NEXT(a_stall_hold, clk, arst_n,
		m_tvalid && !m_tready, m_tvalid && $stable(m_tdata),
		"result changed while stalled")

endmodule

bind indexed_deque idq_checker #(.DEPTH(DEPTH)) u_idq_checker (.*);

// File: bench/indexed_deque_tb.sv
`timescale 1ns / 100ps
// ---------------------------------------------------------------------------
// indexed_deque_tb
// drives deque requests over the slave stream and checks every result on the
// master stream against a behavioral deque kept in the bench; covers empty,
// partly filled and full stores, then long random mixes under varying stalls
// ---------------------------------------------------------------------------
module indexed_deque_tb;
	import idq_pkg::*;

	localparam int DEPTH        = DEPTH_DEF;
	localparam int CYCLE_LIMIT  = 200000;
	localparam int SETTLE_TICKS = 8;

	typedef struct {
		logic [DATA_W-1:0]  data;
		status_t            status;
		logic [COUNT_W-1:0] count;
	} deque_result_t;

	logic                 clk      = 1'b0;
	logic                 arst_n   = 1'b0;
	logic                 s_tvalid = 1'b0;
	logic                 s_tready;
	logic [S_TDATA_W-1:0] s_tdata  = '0;  // mode, value, position
	logic                 m_tvalid;
	logic                 m_tready = 1'b0;
	logic [M_TDATA_W-1:0] m_tdata;   // data_out, status, count

	// bench copy of the store, front at index 0
	logic [DATA_W-1:0] shadow_slots [DEPTH];
	int                shadow_count = 0;

	deque_result_t expected_results[$];
	int send_idle_pct = 0;
	int recv_idle_pct = 0;
	int error_count   = 0;
	int request_count = 0;
	int ok_seen       = 0;
	int miss_seen     = 0;
	int full_seen     = 0;
	int cycle_count   = 0;

	const mode_t non_push_modes[6] = '{MODE_POP_FRONT, MODE_POP_BACK, MODE_REMOVE,
		MODE_GET, MODE_CONTAINS, MODE_PEEK_BACK};

	indexed_deque u_dut (
		.clk      (clk),
		.arst_n   (arst_n),
		.s_tvalid (s_tvalid),
		.s_tready (s_tready),
		.s_tdata  (s_tdata),
		.m_tvalid (m_tvalid),
		.m_tready (m_tready),
		.m_tdata  (m_tdata)
	);

	always #5 clk = ~clk;

	always @(posedge clk) begin
		m_tready <= ($urandom_range(99) >= recv_idle_pct);
	end

	always @(posedge clk) begin
		cycle_count++;
		if (cycle_count > CYCLE_LIMIT) begin
			$display("timeout after %0d cycles, %0d results outstanding", cycle_count,
				expected_results.size());
			$display("indexed_deque_tb failed");
			$finish;
		end
	end

	// take entry idx out of the shadow store and close the gap
	function automatic logic [DATA_W-1:0] shadow_take(input int idx);
		logic [DATA_W-1:0] v;
		v = shadow_slots[idx];
		for (int i = idx; i < shadow_count - 1; i++)
			shadow_slots[i] = shadow_slots[i + 1];
		shadow_count--;
		return v;
	endfunction

	function automatic deque_result_t deque_apply(input mode_t op, input logic [DATA_W-1:0] val,
		input logic [POS_W-1:0] pos);
		deque_result_t r;
		r.data   = '0;
		r.status = ST_OK;
		case (op)
			MODE_PUSH_FRONT: begin
				if (shadow_count >= DEPTH) begin
					r.status = ST_FULL;
				end else begin
					for (int i = shadow_count; i > 0; i--)
						shadow_slots[i] = shadow_slots[i - 1];
					shadow_slots[0] = val;
					shadow_count++;
				end
			end
			MODE_PUSH_BACK: begin
				if (shadow_count >= DEPTH) begin
					r.status = ST_FULL;
				end else begin
					shadow_slots[shadow_count] = val;
					shadow_count++;
				end
			end
			MODE_POP_FRONT: begin
				if (shadow_count == 0) r.status = ST_MISS;
				else r.data = shadow_take(0);
			end
			MODE_POP_BACK: begin
				if (shadow_count == 0) r.status = ST_MISS;
				else r.data = shadow_take(shadow_count - 1);
			end
			MODE_REMOVE: begin
				if (int'(pos) >= shadow_count) r.status = ST_MISS;
				else r.data = shadow_take(int'(pos));
			end
			MODE_GET: begin
				if (int'(pos) >= shadow_count) r.status = ST_MISS;
				else r.data = shadow_slots[pos];
			end
			MODE_CONTAINS: begin
				r.status = ST_MISS;
				for (int i = 0; i < shadow_count; i++)
					if (shadow_slots[i] == val) r.status = ST_OK;
			end
			default: begin
				if (shadow_count == 0) r.status = ST_MISS;
				else r.data = shadow_slots[shadow_count - 1];
			end
		endcase
		r.count = shadow_count[COUNT_W-1:0];
		return r;
	endfunction

	// result checker
	always @(posedge clk) begin : result_check
		deque_result_t want;
		if (arst_n && m_tvalid && m_tready) begin
			if (expected_results.size() == 0) begin
				$display("%0t: result with nothing outstanding, expected none actual %h",
					$time, m_tdata);
				error_count++;
			end else begin
				want = expected_results.pop_front();
				if (m_tdata[31:0] !== want.data) begin
					$display("%0t: data_out mismatch, expected %h actual %h", $time,
						want.data, m_tdata[31:0]);
					error_count++;
				end
				if (m_tdata[33:32] !== want.status) begin
					$display("%0t: status mismatch, expected %0d actual %0d", $time,
						want.status, m_tdata[33:32]);
					error_count++;
				end
				if (m_tdata[38:34] !== want.count) begin
					$display("%0t: count mismatch, expected %0d actual %0d", $time,
						want.count, m_tdata[38:34]);
					error_count++;
				end
				case (want.status)
					ST_OK:   ok_seen++;
					ST_MISS: miss_seen++;
					default: full_seen++;
				endcase
			end
		end
	end

	task automatic send_request(input mode_t op, input logic [DATA_W-1:0] val,
		input logic [POS_W-1:0] pos);
		while ($urandom_range(99) < send_idle_pct) begin
			s_tvalid <= 1'b0;
			@(posedge clk);
		end
		s_tvalid <= 1'b1;
		s_tdata  <= {1'b0, pos, val, op};
		do @(posedge clk); while (!s_tready);
		expected_results.push_back(deque_apply(op, val, pos));
		request_count++;
	endtask

	// hold the sender until every outstanding result is back
	task automatic wait_for_results();
		s_tvalid <= 1'b0;
		do @(posedge clk); while (expected_results.size() != 0);
		repeat (SETTLE_TICKS) @(posedge clk);
	endtask

	function automatic logic [DATA_W-1:0] rand_value();
		case ($urandom_range(7))
			0:       return '0;
			1:       return '1;
			default: return $urandom;
		endcase
	endfunction

	task automatic test_empty_store();
		send_request(MODE_POP_FRONT, 32'h0, 4'd0);
		send_request(MODE_POP_BACK, 32'h0, 4'd0);
		send_request(MODE_PEEK_BACK, 32'h0, 4'd0);
		send_request(MODE_GET, 32'h0, 4'd0);
		send_request(MODE_GET, 32'h0, 4'd15);
		send_request(MODE_REMOVE, 32'h0, 4'd0);
		send_request(MODE_CONTAINS, 32'h0, 4'd0);
	endtask

	task automatic test_small_store();
		// push back on empty must become front and back at once
		send_request(MODE_PUSH_BACK, 32'hFFFF_FFFF, 4'd0);
		send_request(MODE_PEEK_BACK, 32'h0, 4'd0);
		send_request(MODE_GET, 32'h0, 4'd0);
		send_request(MODE_PUSH_FRONT, 32'h0000_0000, 4'd15);
		send_request(MODE_GET, 32'h0, 4'd1);
		send_request(MODE_GET, 32'h0, 4'd2);
		send_request(MODE_CONTAINS, 32'hFFFF_FFFF, 4'd0);
		send_request(MODE_CONTAINS, 32'h1234_5678, 4'd0);
		send_request(MODE_PUSH_BACK, 32'hA5A5_5A5A, 4'd0);
		send_request(MODE_REMOVE, 32'h0, 4'd1);
		send_request(MODE_REMOVE, 32'h0, 4'd15);
		send_request(MODE_POP_BACK, 32'h0, 4'd0);
		send_request(MODE_POP_FRONT, 32'h0, 4'd0);
		send_request(MODE_PEEK_BACK, 32'h0, 4'd0);
	endtask

	task automatic test_full_store();
		logic [DATA_W-1:0] v;
		for (int i = 0; i < DEPTH; i++) begin
			v = rand_value();
			if (i % 2 == 0) send_request(MODE_PUSH_BACK, v, 4'($urandom_range(15)));
			else send_request(MODE_PUSH_FRONT, v, 4'($urandom_range(15)));
		end
		send_request(MODE_PUSH_FRONT, rand_value(), 4'd0);
		send_request(MODE_PUSH_BACK, rand_value(), 4'd0);
		send_request(MODE_GET, 32'h0, 4'd15);
		send_request(MODE_CONTAINS, shadow_slots[DEPTH-1], 4'd0);
		send_request(MODE_REMOVE, 32'h0, 4'd7);
		send_request(MODE_PUSH_FRONT, rand_value(), 4'd0);
		send_request(MODE_REMOVE, 32'h0, 4'd15);
		send_request(MODE_PEEK_BACK, 32'h0, 4'd0);
		while (shadow_count > 0)
			send_request($urandom_range(1) ? MODE_POP_FRONT : MODE_POP_BACK, 32'h0, 4'd0);
	endtask

	// alternates push-heavy and pop-heavy stretches so both full and empty are hit
	task automatic test_random_mix(input int n_requests);
		mode_t             op;
		logic [DATA_W-1:0] v;
		logic [POS_W-1:0]  pos;
		int                push_weight;
		for (int k = 0; k < n_requests; k++) begin
			push_weight = ((k / 50) % 2 == 0) ? 70 : 15;
			if ($urandom_range(99) < push_weight)
				op = $urandom_range(1) ? MODE_PUSH_FRONT : MODE_PUSH_BACK;
			else
				op = non_push_modes[$urandom_range(5)];
			if (op == MODE_CONTAINS && shadow_count > 0 && $urandom_range(1))
				v = shadow_slots[$urandom_range(shadow_count - 1)];
			else
				v = rand_value();
			if (shadow_count > 0 && $urandom_range(3) != 0)
				pos = POS_W'($urandom_range(shadow_count - 1));
			else
				pos = POS_W'($urandom_range(15));
			send_request(op, v, pos);
		end
	endtask

	initial begin
		repeat (7) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		send_idle_pct = 26;
		recv_idle_pct = 54;
		test_empty_store();
		test_small_store();
		wait_for_results();
		test_full_store();
		test_random_mix(200);
		wait_for_results();

		send_idle_pct = 54;
		recv_idle_pct = 26;
		test_random_mix(200);
		wait_for_results();

		send_idle_pct = 0;
		recv_idle_pct = 0;
		test_random_mix(200);
		wait_for_results();

		$display("%0d requests over empty, partial and full stores in %0d cycles", request_count,
			cycle_count);
		$display("results: %0d ok, %0d empty or miss, %0d refused as full, %0d errors", ok_seen,
			miss_seen, full_seen, error_count);
		if (error_count == 0) begin
			$display("indexed_deque_tb passed");
		end else begin
			$display("indexed_deque_tb failed");
		end
		$finish;
	end

endmodule
